[design/modem_escape_sequence_detector_defines.svh]
// Assertion macros for the modem escape sequence detector checker.
`ifndef MODEM_ESCAPE_SEQUENCE_DETECTOR_DEFINES_SVH
`define MODEM_ESCAPE_SEQUENCE_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MESD_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MESD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[design/mesd_pkg.sv]
// Shared types and constants of the modem escape sequence detector.
package mesd_pkg;

    localparam int ByteW  = 8;
    localparam int GuardW = 16;
    localparam int HeldW  = 2;
    localparam int KindW  = 2;
    localparam int ActW   = 2;

    // Input action codes
    localparam logic [ActW-1:0] ACT_BYTE    = 2'd0;
    localparam logic [ActW-1:0] ACT_TICK    = 2'd1;
    localparam logic [ActW-1:0] ACT_ONLINE  = 2'd2;
    localparam logic [ActW-1:0] ACT_COMMAND = 2'd3;

    // Result kinds
    localparam logic [KindW-1:0] KIND_DATA   = 2'd0;
    localparam logic [KindW-1:0] KIND_CMD    = 2'd1;
    localparam logic [KindW-1:0] KIND_ESCAPE = 2'd2;

    // Register indexes
    localparam logic REG_GUARD  = 1'b0;
    localparam logic REG_ESCAPE = 1'b1;

    localparam logic [GuardW-1:0] GUARD_RESET  = 16'd1000;
    localparam logic [ByteW-1:0]  ESCAPE_RESET = 8'd43;

    // Results one item releases: rel_cnt escape chars, then an optional final result
    typedef struct packed {
        logic [HeldW-1:0] rel_cnt;
        logic [ByteW-1:0] esc_byte;
        logic             fin_valid;
        logic [KindW-1:0] fin_kind;
        logic [ByteW-1:0] fin_byte;
    } burst_t;

endpackage

[design/modem_escape_sequence_detector.sv]
// Modem escape sequence detector: guard-time escape detection on a terminal byte stream.
// A request's first result passes the input, burst and output registers before it is shown.
// Throughput: one request per cycle while each causes at most one result and m_tready is high;
//   a request that releases held escape chars sends up to 4 results, one per cycle while m_tready is high.
// Reset (async, rst_n low): command mode, no held chars, idle ticks 0, guard 1000, escape '+'.
module modem_escape_sequence_detector #(
    parameter int ESCAPE_LENGTH = 3    // escape chars needed, 1..3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration writes: index 0 guard_ticks, 1 escape_char
    input  logic                        cfg_we,
    input  logic                        cfg_addr,
    input  logic [mesd_pkg::GuardW-1:0] cfg_data,
    // terminal requests
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mesd_pkg::ByteW-1:0]  s_tdata,   // [7:0] byte_in
    input  logic [mesd_pkg::ActW-1:0]   s_tuser,   // [1:0] action
    // results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mesd_pkg::ByteW-1:0]  m_tdata,   // [7:0] byte_out
    output logic [mesd_pkg::KindW-1:0]  m_tuser,   // [1:0] kind
    output logic                        m_tlast    // final result of a request
);

    mesd_pkg::burst_t burst;
    logic             burst_load;
    logic             load_ok;

    // Input register plus mode state; decides one request per cycle while the emitter can load it.
    mesd_core #(
        .ESCAPE_LENGTH(ESCAPE_LENGTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tuser),
        .in_byte    (s_tdata),
        .load_ok    (load_ok),
        .burst_load (burst_load),
        .burst      (burst)
    );

    // Held escape chars go out first, then the request's own result with tlast.
    mesd_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .burst_load (burst_load),
        .burst      (burst),
        .load_ok    (load_ok),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

[design/mesd_core.sv]
// Input register, mode state and per-item decision logic.
module mesd_core #(
    parameter int ESCAPE_LENGTH = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_addr,
    input  logic [mesd_pkg::GuardW-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mesd_pkg::ActW-1:0]   in_action,
    input  logic [mesd_pkg::ByteW-1:0]  in_byte,
    input  logic                        load_ok,
    output logic                        burst_load,
    output mesd_pkg::burst_t            burst
);

    localparam logic [mesd_pkg::HeldW-1:0] EscLen = mesd_pkg::HeldW'(ESCAPE_LENGTH);

    logic                        item_valid_reg;
    logic [mesd_pkg::ActW-1:0]   action_reg;
    logic [mesd_pkg::ByteW-1:0]  byte_reg;

    logic [mesd_pkg::GuardW-1:0] guard_reg;
    logic [mesd_pkg::ByteW-1:0]  esc_reg;

    logic                        online_reg, online_next;
    logic [mesd_pkg::HeldW-1:0]  held_reg, held_next;
    logic [mesd_pkg::GuardW-1:0] idle_reg, idle_next;
    logic [mesd_pkg::GuardW-1:0] idle_tick;
    logic                        hold_ok;

    assign burst_load = item_valid_reg && load_ok;
    assign in_ready   = !item_valid_reg || load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            action_reg <= in_action;
            byte_reg   <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            guard_reg <= mesd_pkg::GUARD_RESET;
            esc_reg   <= mesd_pkg::ESCAPE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == mesd_pkg::REG_GUARD)
            begin
                guard_reg <= cfg_data;
            end
            else
            begin
                esc_reg <= cfg_data[mesd_pkg::ByteW-1:0];
            end
        end
    end

    // saturating tick count; also drops to a lowered guard
    assign idle_tick = (idle_reg < guard_reg) ? idle_reg + 1'b1 : guard_reg;
    assign hold_ok   = (byte_reg == esc_reg) && (held_reg < EscLen)
                       && ((held_reg != '0) || (idle_reg >= guard_reg));

    always_comb
    begin
        online_next     = online_reg;
        held_next       = held_reg;
        idle_next       = idle_reg;
        burst.rel_cnt   = '0;
        burst.esc_byte  = esc_reg;
        burst.fin_valid = 1'b0;
        burst.fin_kind  = mesd_pkg::KIND_DATA;
        burst.fin_byte  = byte_reg;
        case (action_reg)
            mesd_pkg::ACT_BYTE:
            begin
                if (!online_reg)
                begin
                    burst.fin_valid = 1'b1;
                    burst.fin_kind  = mesd_pkg::KIND_CMD;
                end
                else if (hold_ok)
                begin
                    held_next = held_reg + 1'b1;
                    idle_next = '0;
                end
                else
                begin
                    burst.rel_cnt   = held_reg;
                    burst.fin_valid = 1'b1;
                    held_next       = '0;
                    idle_next       = '0;
                end
            end
            mesd_pkg::ACT_TICK:
            begin
                idle_next = idle_tick;
                if (online_reg && (held_reg == EscLen) && (idle_tick >= guard_reg))
                begin
                    online_next     = 1'b0;
                    held_next       = '0;
                    burst.fin_valid = 1'b1;
                    burst.fin_kind  = mesd_pkg::KIND_ESCAPE;
                    burst.fin_byte  = '0;
                end
            end
            mesd_pkg::ACT_ONLINE:
            begin
                online_next = 1'b1;
                held_next   = '0;
                idle_next   = '0;
            end
            default:
            begin
                online_next = 1'b0;
                held_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            online_reg <= 1'b0;
            held_reg   <= '0;
            idle_reg   <= '0;
        end
        else if (burst_load)
        begin
            online_reg <= online_next;
            held_reg   <= held_next;
            idle_reg   <= idle_next;
        end
    end

endmodule

[design/mesd_emit.sv]
// Result sequencer: unrolls one item's results into the output register.
module mesd_emit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       burst_load,
    input  mesd_pkg::burst_t           burst,
    output logic                       load_ok,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [mesd_pkg::ByteW-1:0] m_tdata,
    output logic [mesd_pkg::KindW-1:0] m_tuser,
    output logic                       m_tlast
);

    mesd_pkg::burst_t           burst_reg;
    logic                       out_valid_reg;
    logic [mesd_pkg::ByteW-1:0] out_byte_reg;
    logic [mesd_pkg::KindW-1:0] out_kind_reg;
    logic                       out_last_reg;
    logic                       adv;
    logic                       burst_empty;

    assign adv         = !out_valid_reg || m_tready;
    assign burst_empty = (burst_reg.rel_cnt == '0) && !burst_reg.fin_valid;
    // released chars are always followed by a final result
    assign load_ok     = burst_empty || (adv && (burst_reg.rel_cnt == '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= !burst_empty;
            end
            if (burst_load)
            begin
                burst_reg <= burst;
            end
            else if (adv && (burst_reg.rel_cnt != '0))
            begin
                burst_reg.rel_cnt <= burst_reg.rel_cnt - 1'b1;
            end
            else if (adv)
            begin
                burst_reg.fin_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (burst_reg.rel_cnt != '0)
            begin
                out_byte_reg <= burst_reg.esc_byte;
                out_kind_reg <= mesd_pkg::KIND_DATA;
                out_last_reg <= 1'b0;
            end
            else
            begin
                out_byte_reg <= burst_reg.fin_byte;
                out_kind_reg <= burst_reg.fin_kind;
                out_last_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

[design/mesd_checker.sv]
// Port-level checker for the modem escape sequence detector, with its bind.
`include "modem_escape_sequence_detector_defines.svh"

module mesd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [mesd_pkg::ByteW-1:0] m_tdata,
    input logic [mesd_pkg::KindW-1:0] m_tuser,
    input logic                       m_tlast
);

    `MESD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "stalled result changed")
    `MESD_ASSERT_NOW(a_kind_legal, clk, rst_n, m_tvalid,
        m_tuser == mesd_pkg::KIND_DATA || m_tuser == mesd_pkg::KIND_CMD
        || m_tuser == mesd_pkg::KIND_ESCAPE, "illegal result kind")
    `MESD_ASSERT_NOW(a_escape_form, clk, rst_n, m_tvalid && m_tuser == mesd_pkg::KIND_ESCAPE,
        m_tdata == '0 && m_tlast, "escape result not zero byte with tlast")
    `MESD_ASSERT_NOW(a_cmd_single, clk, rst_n, m_tvalid && m_tuser == mesd_pkg::KIND_CMD,
        m_tlast, "command byte not a single result")

endmodule

bind modem_escape_sequence_detector mesd_checker u_mesd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[dv/tb_modem_escape_sequence_detector.sv]
// Testbench for the modem escape sequence detector: predicted results vs. the stream output.
`timescale 1ns / 100ps

module tb_modem_escape_sequence_detector;

    localparam int ESC_LEN       = 3;      // escape chars that make up one escape
    localparam int SETTLE_CYCLES = 8;      // margin for a request still inside the block
    localparam int CYCLE_LIMIT   = 300000; // hard stop well above the worst-case run
    localparam int DRAIN_LIMIT   = 5000;

    // One result as the stream carries it
    typedef struct packed {
        logic [mesd_pkg::KindW-1:0] kind;
        logic [mesd_pkg::ByteW-1:0] value;
        logic                       last;
    } release_t;

    // Tracks mode, held escape chars and idle ticks; keeps the results still due.
    class escape_tracker;
        logic [mesd_pkg::GuardW-1:0] guard_ticks;
        logic [mesd_pkg::ByteW-1:0]  escape_char;
        bit                          online;
        int                          held;
        int                          idle_ticks;
        release_t                    due_results[$];
        int                          failures;

        function new();
            guard_ticks = mesd_pkg::GUARD_RESET;
            escape_char = mesd_pkg::ESCAPE_RESET;
            online      = 1'b0;
            held        = 0;
            idle_ticks  = 0;
            failures    = 0;
        endfunction

        function void set_register(logic addr, logic [mesd_pkg::GuardW-1:0] data);
            if (addr == mesd_pkg::REG_GUARD)
                guard_ticks = data;
            else
                escape_char = data[mesd_pkg::ByteW-1:0];
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        // Work out what one accepted request releases.
        function void note_request(logic [mesd_pkg::ActW-1:0] act,
                                   logic [mesd_pkg::ByteW-1:0] b);
            release_t burst[$];
            release_t r;
            int k;
            case (act)
                mesd_pkg::ACT_BYTE:
                begin
                    if (!online)
                    begin
                        burst.push_back('{mesd_pkg::KIND_CMD, b, 1'b0});
                    end
                    else if (b == escape_char && held < ESC_LEN
                             && (held > 0 || idle_ticks >= guard_ticks))
                    begin
                        held++;
                        idle_ticks = 0;
                    end
                    else
                    begin
                        // held chars come out as the escape char in force now
                        for (k = 0; k < held; k++)
                            burst.push_back('{mesd_pkg::KIND_DATA, escape_char, 1'b0});
                        held = 0;
                        burst.push_back('{mesd_pkg::KIND_DATA, b, 1'b0});
                        idle_ticks = 0;
                    end
                end
                mesd_pkg::ACT_TICK:
                begin
                    // saturate at guard, and drop to it if guard was lowered
                    if (idle_ticks < guard_ticks)
                        idle_ticks++;
                    else
                        idle_ticks = guard_ticks;
                    if (online && held == ESC_LEN && idle_ticks >= guard_ticks)
                    begin
                        online = 1'b0;
                        held   = 0;
                        burst.push_back('{mesd_pkg::KIND_ESCAPE, 8'h00, 1'b0});
                    end
                end
                mesd_pkg::ACT_ONLINE:
                begin
                    online     = 1'b1;
                    held       = 0;
                    idle_ticks = 0;
                end
                default:
                begin
                    online = 1'b0;
                    held   = 0;
                end
            endcase
            for (k = 0; k < burst.size(); k++)
            begin
                r = burst[k];
                r.last = (k == burst.size() - 1);
                due_results.push_back(r);
            end
        endfunction

        function void flag(string what, release_t want, release_t got);
            failures++;
            if (failures <= 10)
                $display("%s: expected kind %0d byte %02h last %0d, got kind %0d byte %02h last %0d",
                         what, want.kind, want.value, want.last,
                         got.kind, got.value, got.last);
        endfunction

        function void check_result(logic [mesd_pkg::KindW-1:0] kind,
                                   logic [mesd_pkg::ByteW-1:0] b, logic last);
            release_t got;
            release_t want;
            got = '{kind, b, last};
            if (due_results.size() == 0)
            begin
                flag("unexpected result", '0, got);
                return;
            end
            want = due_results.pop_front();
            if (want !== got)
                flag("mismatch", want, got);
        endfunction

        function void close_out();
            if (due_results.size() != 0)
            begin
                $display("%0d expected results never arrived", due_results.size());
                failures += due_results.size();
            end
        endfunction
    endclass

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          cfg_we   = 1'b0;
    logic                          cfg_addr = mesd_pkg::REG_GUARD;
    logic [mesd_pkg::GuardW-1:0]   cfg_data = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [mesd_pkg::ByteW-1:0]    s_tdata  = '0;
    logic [mesd_pkg::ActW-1:0]     s_tuser  = mesd_pkg::ACT_BYTE;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [mesd_pkg::ByteW-1:0]    m_tdata;
    logic [mesd_pkg::KindW-1:0]    m_tuser;
    logic                          m_tlast;

    escape_tracker tracker;
    int            burst_left = 0;  // requests left in the current sender burst
    int            sent_count = 0;  // requests accepted so far
    int            cycle_count = 0;

    modem_escape_sequence_detector #(
        .ESCAPE_LENGTH(ESC_LEN)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] byte_in
        .s_tuser  (s_tuser),    // [1:0] action
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] byte_out
        .m_tuser  (m_tuser),    // [1:0] kind
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: the stall style is picked anew at random; style 0 never stalls,
    // style 2 holds ready low for random runs, style 3 toggles every cycle.
    int ready_style = 0;
    int style_left  = 0;
    int hold_left   = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (style_left == 0)
            begin
                ready_style = $urandom_range(0, 3);
                style_left  = $urandom_range(50, 300);
            end
            else
            begin
                style_left--;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (ready_style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2:
                    begin
                        if ($urandom_range(0, 4) == 0)
                        begin
                            hold_left = $urandom_range(1, 14);
                            m_tready <= 1'b0;
                        end
                        else
                        begin
                            m_tready <= 1'b1;
                        end
                    end
                    default: m_tready <= style_left[0];
                endcase
            end
        end
    end

    // Every accepted result is checked against the oldest one due
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tuser, m_tdata, m_tlast);
    end

    // Send one request. The sender works in bursts; between bursts it drops valid for a
    // random gap. Inside a burst valid stays high from one request to the next.
    task automatic send_request(input logic [mesd_pkg::ActW-1:0] act,
                                input logic [mesd_pkg::ByteW-1:0] b);
        int pause;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                pause = $urandom_range(1, 8);
                s_tvalid <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        tracker.note_request(act, b);
        sent_count++;
    endtask

    task automatic send_byte(input logic [mesd_pkg::ByteW-1:0] b);
        send_request(mesd_pkg::ACT_BYTE, b);
    endtask

    // Non-byte actions carry a random byte that the block must ignore
    task automatic send_action(input logic [mesd_pkg::ActW-1:0] act);
        send_request(act, 8'($urandom()));
    endtask

    task automatic tick_run(input int n);
        repeat (n) send_action(mesd_pkg::ACT_TICK);
    endtask

    // Registers change only while the block is idle: no request open, every result out,
    // and a settling margin for a request that releases nothing to clear the pipeline.
    task automatic apply_settings(input logic [mesd_pkg::GuardW-1:0] guard,
                                  input logic [mesd_pkg::ByteW-1:0] esc);
        logic [mesd_pkg::ByteW-1:0] upper;
        upper = 8'($urandom());
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= mesd_pkg::REG_GUARD;
        cfg_data <= guard;
        @(posedge clk);
        // upper bits of the escape write are junk the block must drop
        cfg_addr <= mesd_pkg::REG_ESCAPE;
        cfg_data <= {upper, esc};
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_register(mesd_pkg::REG_GUARD, guard);
        tracker.set_register(mesd_pkg::REG_ESCAPE, {upper, esc});
    endtask

    // Tick count around the guard time: short, exact or long by one. Long guards are cut.
    function automatic int guard_pad();
        int n;
        n = (tracker.guard_ticks > 8) ? $urandom_range(0, 8) : int'(tracker.guard_ticks);
        case ($urandom_range(0, 3))
            0: n = (n > 0) ? n - 1 : 0;
            1: n = n + 1;
            default: ;
        endcase
        return n;
    endfunction

    // Guard, escape chars, guard: mostly the proper three, sometimes too few or too many,
    // sometimes broken by a stray byte or tick.
    task automatic escape_attempt();
        int count;
        int k;
        if (!tracker.online || $urandom_range(0, 5) == 0)
            send_action(mesd_pkg::ACT_ONLINE);
        tick_run(guard_pad());
        case ($urandom_range(0, 7))
            0: count = 1;
            1: count = 2;
            2: count = 4;
            default: count = ESC_LEN;
        endcase
        for (k = 0; k < count; k++)
        begin
            send_byte(tracker.escape_char);
            case ($urandom_range(0, 15))
                0: send_byte(8'($urandom()));
                1: send_action(mesd_pkg::ACT_TICK);
                default: ;
            endcase
        end
        tick_run(guard_pad());
    endtask

    task automatic random_phase(input int budget);
        int sent_start;
        int k;
        sent_start = sent_count;
        while (sent_count - sent_start < budget)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    escape_attempt();
                end
                5, 6, 7:
                begin
                    for (k = $urandom_range(1, 6); k > 0; k--)
                    begin
                        if ($urandom_range(0, 4) == 0)
                            send_byte(tracker.escape_char);
                        else
                            send_byte(8'($urandom()));
                    end
                end
                8:
                begin
                    send_action(tracker.online ? mesd_pkg::ACT_COMMAND
                                               : mesd_pkg::ACT_ONLINE);
                end
                default:
                begin
                    // noise: any action, any byte
                    for (k = $urandom_range(1, 4); k > 0; k--)
                    begin
                        send_request(mesd_pkg::ActW'($urandom()), 8'($urandom()));
                    end
                end
            endcase
        end
    endtask

    task automatic run_directed();
        // reset settings: guard 1000, '+'
        send_byte(8'h00);                        // command mode, lowest byte
        send_byte(8'hFF);                        // command mode, highest byte
        send_action(mesd_pkg::ACT_COMMAND);      // already in command mode
        send_action(mesd_pkg::ACT_ONLINE);
        send_byte(mesd_pkg::ESCAPE_RESET);       // no guard time yet: passes as data

        apply_settings(16'd2, mesd_pkg::ESCAPE_RESET);
        send_action(mesd_pkg::ACT_ONLINE);
        tick_run(2);
        repeat (ESC_LEN + 1) send_byte(mesd_pkg::ESCAPE_RESET);  // fourth releases all four
        tick_run(2);
        repeat (ESC_LEN) send_byte(mesd_pkg::ESCAPE_RESET);
        tick_run(2);                             // escape fires on the second tick
        send_byte(8'hA5);                        // back in command mode

        apply_settings(16'd0, 8'h2D);            // guard zero, escape '-'
        send_action(mesd_pkg::ACT_ONLINE);
        send_byte(8'h2D);
        send_byte(8'h2D);
        apply_settings(16'd0, mesd_pkg::ESCAPE_RESET);
        send_byte(8'h78);                        // held chars come out as '+'
        send_byte(mesd_pkg::ESCAPE_RESET);
        send_byte(mesd_pkg::ESCAPE_RESET);
        send_action(mesd_pkg::ACT_COMMAND);      // held chars dropped silently
        send_action(mesd_pkg::ACT_ONLINE);
        repeat (ESC_LEN) send_byte(mesd_pkg::ESCAPE_RESET);
        send_action(mesd_pkg::ACT_TICK);         // guard zero: escape on the first tick
    endtask

    initial
    begin
        logic [mesd_pkg::GuardW-1:0] phase_guard [6];
        int                          phase_budget [6];
        logic [mesd_pkg::ByteW-1:0]  phase_esc;
        int                          ph;
        int                          drain;

        // guard 3 then guard 1 leaves idle ticks above the new guard
        phase_guard  = '{16'd0, 16'd3, 16'd1, 16'hFFFF, 16'd5, 16'd2};
        phase_budget = '{65, 65, 65, 50, 65, 65};
        tracker = new();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: phase_esc = 8'h00;
                1: phase_esc = 8'hFF;
                3, 5: phase_esc = mesd_pkg::ESCAPE_RESET;
                default: phase_esc = 8'($urandom());
            endcase
            apply_settings(phase_guard[ph], phase_esc);
            random_phase(phase_budget[ph]);
        end

        s_tvalid <= 1'b0;
        drain = 0;
        while (tracker.outstanding() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        tracker.close_out();

        if (tracker.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
